### rtl/rv64ie_pkg.sv
// Shared types, opcode constants and mnemonic codes of the RV64I encoder.
`timescale 1ns / 1ps
package rv64ie_pkg;

  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_OP_IMM = 7'b0010011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] F7_BASE    = 7'b0000000;
  localparam logic [6:0] F7_ALT     = 7'b0100000;
  localparam logic [5:0] SRAI_HI    = 6'b010000;
  localparam logic [5:0] SHIFT_HI   = 6'b000000;

  typedef enum logic [5:0] {
    OP_ADD, OP_SUB, OP_XOR, OP_OR, OP_AND, OP_SLL, OP_SRL, OP_SRA,
    OP_ADDI, OP_XORI, OP_ORI, OP_ANDI, OP_SLLI, OP_SRLI, OP_SRAI,
    OP_LD, OP_LW, OP_LH, OP_LB, OP_LBU, OP_LHU, OP_LWU, OP_JALR,
    OP_SB, OP_SH, OP_SW, OP_SD,
    OP_BEQ, OP_BGE, OP_BLT, OP_BNE, OP_BLTU, OP_BGEU,
    OP_JAL, OP_LUI
  } op_e;

  typedef enum logic [2:0] {
    FMT_R, FMT_I, FMT_S, FMT_B, FMT_J, FMT_U
  } fmt_e;

  typedef enum logic [1:0] {
    IMM_PLAIN, IMM_SHIFT, IMM_SRAI
  } ikind_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_UNKNOWN = 2'd1,
    ERR_RANGE   = 2'd2
  } err_e;

  // Per-mnemonic encoding description
  typedef struct packed {
    logic        known;
    fmt_e        fmt;
    logic [2:0]  f3;
    logic [6:0]  opc;
    logic [6:0]  f7;
    ikind_e      ikind;
  } desc_t;

  typedef struct packed {
    logic [5:0]         op;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic signed [31:0] immediate;
    logic [31:0]        label_addr;
    logic [31:0]        inst_addr;
  } item_t;

endpackage

### rtl/rv64ie_in_if.sv
// Input channel: one instruction per transfer.
`timescale 1ns / 1ps
interface rv64ie_in_if;
  logic               valid;
  logic               ready;
  logic [5:0]         op;
  logic [4:0]         dest_reg;
  logic [4:0]         src1_reg;
  logic [4:0]         src2_reg;
  logic signed [31:0] immediate;
  logic [31:0]        label_addr;
  logic [31:0]        inst_addr;

  modport source (
    output valid, op, dest_reg, src1_reg, src2_reg, immediate, label_addr, inst_addr,
    input  ready
  );
  modport sink (
    input  valid, op, dest_reg, src1_reg, src2_reg, immediate, label_addr, inst_addr,
    output ready
  );
endinterface

### rtl/rv64ie_out_if.sv
// Output channel: machine word and error code per transfer.
`timescale 1ns / 1ps
interface rv64ie_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] machine_word;
  logic [1:0]  error_code;

  modport source (output valid, machine_word, error_code, input ready);
  modport sink (input valid, machine_word, error_code, output ready);
endinterface

### rtl/rv64ie_decode.sv
// Mnemonic decoder: format, funct3, funct7 and opcode per mnemonic code.
`timescale 1ns / 1ps
module rv64ie_decode import rv64ie_pkg::*; (
  input  logic [5:0] op_i,
  output desc_t      desc_o
);

  function automatic desc_t mk(fmt_e fmt, logic [2:0] f3, logic [6:0] opc,
                               logic [6:0] f7, ikind_e ikind);
    desc_t d;
    d.known = 1'b1;
    d.fmt   = fmt;
    d.f3    = f3;
    d.opc   = opc;
    d.f7    = f7;
    d.ikind = ikind;
    return d;
  endfunction

  always_comb begin
    unique case (op_i)
      OP_ADD:  desc_o = mk(FMT_R, 3'd0, OPC_OP, F7_BASE, IMM_PLAIN);
      OP_SUB:  desc_o = mk(FMT_R, 3'd0, OPC_OP, F7_ALT,  IMM_PLAIN);
      OP_XOR:  desc_o = mk(FMT_R, 3'd4, OPC_OP, F7_BASE, IMM_PLAIN);
      OP_OR:   desc_o = mk(FMT_R, 3'd6, OPC_OP, F7_BASE, IMM_PLAIN);
      OP_AND:  desc_o = mk(FMT_R, 3'd7, OPC_OP, F7_BASE, IMM_PLAIN);
      OP_SLL:  desc_o = mk(FMT_R, 3'd1, OPC_OP, F7_BASE, IMM_PLAIN);
      OP_SRL:  desc_o = mk(FMT_R, 3'd5, OPC_OP, F7_BASE, IMM_PLAIN);
      OP_SRA:  desc_o = mk(FMT_R, 3'd5, OPC_OP, F7_ALT,  IMM_PLAIN);
      OP_ADDI: desc_o = mk(FMT_I, 3'd0, OPC_OP_IMM, F7_BASE, IMM_PLAIN);
      OP_XORI: desc_o = mk(FMT_I, 3'd4, OPC_OP_IMM, F7_BASE, IMM_PLAIN);
      OP_ORI:  desc_o = mk(FMT_I, 3'd6, OPC_OP_IMM, F7_BASE, IMM_PLAIN);
      OP_ANDI: desc_o = mk(FMT_I, 3'd7, OPC_OP_IMM, F7_BASE, IMM_PLAIN);
      OP_SLLI: desc_o = mk(FMT_I, 3'd1, OPC_OP_IMM, F7_BASE, IMM_SHIFT);
      OP_SRLI: desc_o = mk(FMT_I, 3'd5, OPC_OP_IMM, F7_BASE, IMM_SHIFT);
      OP_SRAI: desc_o = mk(FMT_I, 3'd5, OPC_OP_IMM, F7_BASE, IMM_SRAI);
      OP_LD:   desc_o = mk(FMT_I, 3'd3, OPC_LOAD, F7_BASE, IMM_PLAIN);
      OP_LW:   desc_o = mk(FMT_I, 3'd2, OPC_LOAD, F7_BASE, IMM_PLAIN);
      OP_LH:   desc_o = mk(FMT_I, 3'd1, OPC_LOAD, F7_BASE, IMM_PLAIN);
      OP_LB:   desc_o = mk(FMT_I, 3'd0, OPC_LOAD, F7_BASE, IMM_PLAIN);
      OP_LBU:  desc_o = mk(FMT_I, 3'd4, OPC_LOAD, F7_BASE, IMM_PLAIN);
      OP_LHU:  desc_o = mk(FMT_I, 3'd5, OPC_LOAD, F7_BASE, IMM_PLAIN);
      OP_LWU:  desc_o = mk(FMT_I, 3'd6, OPC_LOAD, F7_BASE, IMM_PLAIN);
      OP_JALR: desc_o = mk(FMT_I, 3'd0, OPC_JALR, F7_BASE, IMM_PLAIN);
      OP_SB:   desc_o = mk(FMT_S, 3'd0, OPC_STORE, F7_BASE, IMM_PLAIN);
      OP_SH:   desc_o = mk(FMT_S, 3'd1, OPC_STORE, F7_BASE, IMM_PLAIN);
      OP_SW:   desc_o = mk(FMT_S, 3'd2, OPC_STORE, F7_BASE, IMM_PLAIN);
      OP_SD:   desc_o = mk(FMT_S, 3'd3, OPC_STORE, F7_BASE, IMM_PLAIN);
      OP_BEQ:  desc_o = mk(FMT_B, 3'd0, OPC_BRANCH, F7_BASE, IMM_PLAIN);
      OP_BGE:  desc_o = mk(FMT_B, 3'd5, OPC_BRANCH, F7_BASE, IMM_PLAIN);
      OP_BLT:  desc_o = mk(FMT_B, 3'd4, OPC_BRANCH, F7_BASE, IMM_PLAIN);
      OP_BNE:  desc_o = mk(FMT_B, 3'd1, OPC_BRANCH, F7_BASE, IMM_PLAIN);
      OP_BLTU: desc_o = mk(FMT_B, 3'd6, OPC_BRANCH, F7_BASE, IMM_PLAIN);
      OP_BGEU: desc_o = mk(FMT_B, 3'd7, OPC_BRANCH, F7_BASE, IMM_PLAIN);
      OP_JAL:  desc_o = mk(FMT_J, 3'd0, OPC_JAL, F7_BASE, IMM_PLAIN);
      OP_LUI:  desc_o = mk(FMT_U, 3'd0, OPC_LUI, F7_BASE, IMM_PLAIN);
      default: begin
        desc_o       = mk(FMT_R, 3'd0, 7'd0, F7_BASE, IMM_PLAIN);
        desc_o.known = 1'b0;
      end
    endcase
  end

endmodule

### rtl/rv64ie_pack.sv
// Range checks and field packing of one decoded instruction.
`timescale 1ns / 1ps
module rv64ie_pack import rv64ie_pkg::*; (
  input  desc_t       desc_i,
  input  item_t       item_i,
  output logic [31:0] word_o,
  output err_e        err_o
);

  logic signed [32:0] offs;
  logic [31:0]        imm;
  logic [11:0]        u12;
  logic               ok;
  logic [31:0]        word;

  assign imm  = item_i.immediate;
  // exact signed difference of two unsigned addresses
  assign offs = $signed({1'b0, item_i.label_addr}) - $signed({1'b0, item_i.inst_addr});

  always_comb begin
    ok   = 1'b1;
    u12  = imm[11:0];
    word = '0;
    case (desc_i.fmt)
      FMT_R: begin
        word = {desc_i.f7, item_i.src2_reg, item_i.src1_reg, desc_i.f3,
                item_i.dest_reg, desc_i.opc};
      end
      FMT_I: begin
        if (desc_i.ikind == IMM_PLAIN) begin
          ok  = (&imm[31:11]) || !(|imm[31:11]);
          u12 = imm[11:0];
        end else begin
          ok  = !(|imm[31:6]);
          u12 = {(desc_i.ikind == IMM_SRAI) ? SRAI_HI : SHIFT_HI, imm[5:0]};
        end
        word = {u12, item_i.src1_reg, desc_i.f3, item_i.dest_reg, desc_i.opc};
      end
      FMT_S: begin
        ok   = (&imm[31:11]) || !(|imm[31:11]);
        word = {imm[11:5], item_i.src2_reg, item_i.src1_reg, desc_i.f3,
                imm[4:0], desc_i.opc};
      end
      FMT_B: begin
        // -4096 .. 4094; top value of the 13-bit range is rejected
        ok   = ((&offs[32:12]) || !(|offs[32:12])) && (offs[12:0] != 13'h0FFF);
        word = {offs[12], offs[10:5], item_i.src2_reg, item_i.src1_reg, desc_i.f3,
                offs[4:1], offs[11], desc_i.opc};
      end
      FMT_J: begin
        ok   = ((&offs[32:20]) || !(|offs[32:20])) && (offs[20:0] != 21'h0FFFFF);
        word = {offs[20], offs[10:1], offs[11], offs[19:12], item_i.dest_reg,
                desc_i.opc};
      end
      FMT_U: begin
        ok   = !(|imm[31:20]);
        word = {imm[19:0], item_i.dest_reg, desc_i.opc};
      end
      default: begin
        ok   = 1'b0;
        word = '0;
      end
    endcase
  end

  always_comb begin
    if (!desc_i.known) begin
      err_o  = ERR_UNKNOWN;
      word_o = '0;
    end else if (!ok) begin
      err_o  = ERR_RANGE;
      word_o = '0;
    end else begin
      err_o  = ERR_NONE;
      word_o = word;
    end
  end

endmodule

### rtl/rv64_instruction_encoder.sv
// Top level: input register, decode and pack, output register.
// Decode and pack sit in one stage between the input register and the output
// register; a result is offered from the output register until it transfers.
// Throughput: one instruction per cycle unless the output stalls.
// The input register takes a transfer while a result waits at the output,
// as long as it is empty; a full input register waits for the output.
// Reset clears both valid flags; payload registers are not reset.
`timescale 1ns / 1ps
module rv64_instruction_encoder import rv64ie_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rv64ie_in_if.sink  in_i,
  rv64ie_out_if.source out_o
);

  logic        in_valid_q;
  item_t       item_q;
  logic        out_valid_q;
  logic [31:0] word_q;
  err_e        err_q;

  desc_t       desc;
  logic [31:0] word_d;
  err_e        err_d;
  logic        out_ready;
  logic        in_ready;
  logic        in_xfer;

  assign out_ready = !out_valid_q || out_o.ready;
  assign in_ready  = !in_valid_q || out_ready;
  assign in_xfer   = in_i.valid && in_ready;

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.machine_word = word_q;
  assign out_o.error_code   = err_q;

  rv64ie_decode u_decode (
    .op_i   (item_q.op),
    .desc_o (desc)
  );

  rv64ie_pack u_pack (
    .desc_i (desc),
    .item_i (item_q),
    .word_o (word_d),
    .err_o  (err_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_i.valid;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.op         <= in_i.op;
      item_q.dest_reg   <= in_i.dest_reg;
      item_q.src1_reg   <= in_i.src1_reg;
      item_q.src2_reg   <= in_i.src2_reg;
      item_q.immediate  <= in_i.immediate;
      item_q.label_addr <= in_i.label_addr;
      item_q.inst_addr  <= in_i.inst_addr;
    end
    if (out_ready && in_valid_q) begin
      word_q <= word_d;
      err_q  <= err_d;
    end
  end

  a_err_zero_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && err_q != ERR_NONE) |-> (word_q == '0))
    else $error("error result carries a non-zero word");

  a_ok_has_opcode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && err_q == ERR_NONE) |-> (word_q[1:0] == 2'b11))
    else $error("good result lacks a 32-bit opcode");

  a_unknown_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_ready && item_q.op > OP_LUI) |=>
      (out_valid_q && err_q == ERR_UNKNOWN))
    else $error("unknown mnemonic not reported");

  a_xfer_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_valid_q)
    else $error("input transfer lost");

endmodule
